FILE: rtl/mct_pkg.sv
// shared types and constants for the mouse cursor tracker
`default_nettype none

package mct_pkg;

  // field widths
  localparam int unsigned CountW  = 16;
  localparam int unsigned RatioW  = 8;
  localparam int unsigned PosW    = 12;
  localparam int unsigned BtnN    = 3;
  localparam int unsigned EventW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 104;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ENABLE        = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_X_RATIO       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_Y_RATIO       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 3'd4;

  // reset values of the configuration registers
  localparam logic [RatioW-1:0] RATIO_RESET  = 8'd1;
  localparam logic [PosW-1:0]   WIDTH_RESET  = 12'd639;
  localparam logic [PosW-1:0]   HEIGHT_RESET = 12'd479;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mouse_cursor_tracker_top.sv
// mouse cursor tracker: event sequencer, state and shared divider
//
// usage: one mouse event item enters on the s_axis channel and one cursor
// report item leaves on the m_axis channel for every event accepted.
// the cfg port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes enable, the two
// mickey ratios and the two screen limits; write it only while idle.
// for an enabled event the wrapped counter delta of each axis plus its
// remainder is floor-divided by the axis ratio in one shared serial
// divider, one quotient bit per cycle; each axis goes through start,
// 16 steps and result, x first, and the report is valid once y is done.
// a disabled event changes nothing and is reported in the next cycle.
// s_axis_tready is high only while no event is in work and no report is
// waiting, so one event is handled at a time.
// when the receiver stalls, the report stays on m_axis_tdata with
// m_axis_tvalid high until taken; no new event is taken meanwhile.
// reset clears the cursor, remainders, last counters, buttons, latches and
// captured positions, and sets the registers to 0, 1, 1, 639 and 479.
`default_nettype none

module mouse_cursor_tracker_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [mct_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [mct_pkg::CfgW-1:0]          cfg_wdata_i,
  // event input: event_bits[6:0], count_x[22:7], count_y[38:23],
  // press_ack[41:39], zero fill above
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [mct_pkg::InDataW-1:0]       s_axis_tdata,
  // report output: cursor_x[11:0], cursor_y[23:12], buttons_held[26:24],
  // press_latched[29:27], left_press_x[41:30], left_press_y[53:42],
  // right_press_x[65:54], right_press_y[77:66], middle_press_x[89:78],
  // middle_press_y[101:90], zero fill above
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [mct_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned CountW = mct_pkg::CountW;
  localparam int unsigned RatioW = mct_pkg::RatioW;
  localparam int unsigned PosW   = mct_pkg::PosW;
  localparam int unsigned BtnN   = mct_pkg::BtnN;
  localparam int unsigned TotW   = CountW + 1;
  localparam int unsigned SumW   = CountW + 2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_X_GO  = 6'b000010,
    ST_X_RUN = 6'b000100,
    ST_Y_GO  = 6'b001000,
    ST_Y_RUN = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic                enable_q;
  logic [RatioW-1:0]   x_ratio_q, y_ratio_q;
  logic [PosW-1:0]     width_q, height_q;

  // tracker state
  logic [PosW-1:0]     pos_x_q, pos_y_q;
  logic [RatioW-1:0]   rem_x_q, rem_y_q;
  logic [CountW-1:0]   last_x_q, last_y_q;
  logic [BtnN-1:0]     held_q, latch_q;
  logic [PosW-1:0]     cap_x_q [BtnN];
  logic [PosW-1:0]     cap_y_q [BtnN];

  // event fields kept while the axes are worked
  logic [CountW-1:0]   cnt_x_q, cnt_y_q;
  logic                neg_q;

  // input fields
  logic [mct_pkg::EventW-1:0] in_ev;
  logic [CountW-1:0]          in_cx, in_cy;
  logic [BtnN-1:0]            in_ack;
  logic                       in_acc, out_acc;

  assign in_ev  = s_axis_tdata[6:0];
  assign in_cx  = s_axis_tdata[22:7];
  assign in_cy  = s_axis_tdata[38:23];
  assign in_ack = s_axis_tdata[41:39];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_RESP);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // axis operand selection for the shared divider
  logic                axis_y;
  logic [CountW-1:0]   sel_cnt, sel_last;
  logic [RatioW-1:0]   sel_rem, sel_ratio, eff_ratio;
  logic [PosW-1:0]     sel_pos, sel_limit;
  logic [CountW-1:0]   delta;
  logic [TotW-1:0]     total;
  logic                tot_neg;
  logic [CountW-1:0]   mag;

  assign axis_y    = (state_q == ST_Y_GO) || (state_q == ST_Y_RUN);
  assign sel_cnt   = axis_y ? cnt_y_q   : cnt_x_q;
  assign sel_last  = axis_y ? last_y_q  : last_x_q;
  assign sel_rem   = axis_y ? rem_y_q   : rem_x_q;
  assign sel_ratio = axis_y ? y_ratio_q : x_ratio_q;
  assign sel_pos   = axis_y ? pos_y_q   : pos_x_q;
  assign sel_limit = axis_y ? height_q  : width_q;
  assign eff_ratio = (sel_ratio == '0) ? RatioW'(1) : sel_ratio;

  // remainder plus wrapped delta, then magnitude for floor division
  assign delta   = sel_cnt - sel_last;
  assign total   = {{(TotW - RatioW){1'b0}}, sel_rem} + {delta[CountW-1], delta};
  assign tot_neg = total[TotW-1];
  assign mag     = tot_neg ? ~total[CountW-1:0] : total[CountW-1:0];

  // shared divider
  logic                div_start;
  mct_pkg::div_stat_t  div_stat;
  logic [CountW-1:0]   div_quo;
  logic [RatioW-1:0]   div_rem;

  assign div_start = (state_q == ST_X_GO) || (state_q == ST_Y_GO);

  mct_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag),
    .divisor_i   (eff_ratio),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // floor quotient and remainder, then move and clip
  logic [TotW-1:0]     q_fl;
  logic [RatioW-1:0]   r_fl;
  logic [SumW-1:0]     sum;
  logic [PosW-1:0]     new_pos;

  assign q_fl = neg_q ? ~{1'b0, div_quo} : {1'b0, div_quo};
  assign r_fl = neg_q ? (eff_ratio - RatioW'(1) - div_rem) : div_rem;
  assign sum  = {{(SumW - PosW){1'b0}}, sel_pos} + {q_fl[TotW-1], q_fl};

  always_comb begin
    if (sum[SumW-1]) begin
      new_pos = '0;
    end else if (sum[SumW-2:0] > {{(SumW - 1 - PosW){1'b0}}, sel_limit}) begin
      new_pos = sel_limit;
    end else begin
      new_pos = sum[PosW-1:0];
    end
  end

  // button updates for an accepted event
  logic [BtnN-1:0]     btn_down, btn_up, latch_acked, btn_capture;

  always_comb begin
    for (int b = 0; b < BtnN; b++) begin
      btn_down[b] = in_ev[2 * b + 1];
      btn_up[b]   = in_ev[2 * b + 2];
    end
    latch_acked = latch_q & ~in_ack;
    btn_capture = btn_down & ~latch_acked;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = enable_q ? ST_X_GO : ST_RESP;
        end
      end
      ST_X_GO:  state_d = ST_X_RUN;
      ST_X_RUN: begin
        if (div_stat.done) begin
          state_d = ST_Y_GO;
        end
      end
      ST_Y_GO:  state_d = ST_Y_RUN;
      ST_Y_RUN: begin
        if (div_stat.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      enable_q  <= 1'b0;
      x_ratio_q <= mct_pkg::RATIO_RESET;
      y_ratio_q <= mct_pkg::RATIO_RESET;
      width_q   <= mct_pkg::WIDTH_RESET;
      height_q  <= mct_pkg::HEIGHT_RESET;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      rem_x_q   <= '0;
      rem_y_q   <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      held_q    <= '0;
      latch_q   <= '0;
      for (int b = 0; b < BtnN; b++) begin
        cap_x_q[b] <= '0;
        cap_y_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mct_pkg::CFG_ENABLE:        enable_q  <= cfg_wdata_i[0];
          mct_pkg::CFG_X_RATIO:       x_ratio_q <= cfg_wdata_i[RatioW-1:0];
          mct_pkg::CFG_Y_RATIO:       y_ratio_q <= cfg_wdata_i[RatioW-1:0];
          mct_pkg::CFG_SCREEN_WIDTH:  width_q   <= cfg_wdata_i[PosW-1:0];
          mct_pkg::CFG_SCREEN_HEIGHT: height_q  <= cfg_wdata_i[PosW-1:0];
          default: ;
        endcase
      end
      // buttons and captures, cursor still before the move
      if (in_acc && enable_q) begin
        held_q  <= (held_q | btn_down) & ~btn_up;
        latch_q <= latch_acked | btn_down;
        for (int b = 0; b < BtnN; b++) begin
          if (btn_capture[b]) begin
            cap_x_q[b] <= pos_x_q;
            cap_y_q[b] <= pos_y_q;
          end
        end
      end
      // counters are taken over when each axis starts
      if (state_q == ST_X_GO) begin
        last_x_q <= cnt_x_q;
      end
      if (state_q == ST_Y_GO) begin
        last_y_q <= cnt_y_q;
      end
      // axis results
      if (state_q == ST_X_RUN && div_stat.done) begin
        pos_x_q <= new_pos;
        rem_x_q <= r_fl;
      end
      if (state_q == ST_Y_RUN && div_stat.done) begin
        pos_y_q <= new_pos;
        rem_y_q <= r_fl;
      end
    end
  end

  // event payload and sign of the axis in work
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cnt_x_q <= in_cx;
      cnt_y_q <= in_cy;
    end
    if (div_start) begin
      neg_q <= tot_neg;
    end
  end

  // report packing
  assign m_axis_tdata = {
    2'b00,
    cap_y_q[2], cap_x_q[2],
    cap_y_q[1], cap_x_q[1],
    cap_y_q[0], cap_x_q[0],
    latch_q, held_q,
    pos_y_q, pos_x_q
  };

  // checks
  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy) else $error("divider started while busy");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_X_RUN) || (state_q == ST_Y_RUN)) |-> (div_stat.busy || div_stat.done))
    else $error("axis wait with divider idle");

  a_pos_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_Y_RUN && state_q == ST_RESP)
      |-> (pos_x_q <= width_q) && (pos_y_q <= height_q))
    else $error("cursor outside screen after enabled event");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("report changed while stalled");

endmodule

`default_nettype wire

FILE: rtl/mct_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module mct_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [mct_pkg::CountW-1:0]     dividend_i,
  input  wire logic [mct_pkg::RatioW-1:0]     divisor_i,
  output mct_pkg::div_stat_t                  stat_o,
  output logic      [mct_pkg::CountW-1:0]     quotient_o,
  output logic      [mct_pkg::RatioW-1:0]     remainder_o
);

  localparam int unsigned CntW = $clog2(mct_pkg::CountW);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [mct_pkg::CountW-1:0]  dq_q, dq_d;
  logic [mct_pkg::RatioW-1:0]  rem_q, rem_d;
  logic [mct_pkg::RatioW-1:0]  div_q, div_d;
  logic [mct_pkg::RatioW:0]    trial;
  logic [mct_pkg::RatioW:0]    diff;
  logic                        fits;

  // trial subtract of the shifted partial remainder
  assign trial = {rem_q, dq_q[mct_pkg::CountW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // one step per cycle while busy
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[mct_pkg::CountW-2:0], fits};
      rem_d = fits ? diff[mct_pkg::RatioW-1:0] : trial[mct_pkg::RatioW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(mct_pkg::CountW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = dq_q;
  assign remainder_o  = rem_q;

  // checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q) || (div_q == '0))
    else $error("divider remainder not below divisor");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench for the mouse cursor tracker
`timescale 1ns / 100ps

module tb;

  // event item as packed on s_axis_tdata, lowest field last
  typedef struct packed {
    logic [5:0]  fill;
    logic [2:0]  ack;
    logic [15:0] cnt_y;
    logic [15:0] cnt_x;
    logic [6:0]  bits;
  } mouse_event_t;

  // cursor report as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  fill;
    logic [11:0] mid_y;
    logic [11:0] mid_x;
    logic [11:0] right_y;
    logic [11:0] right_x;
    logic [11:0] left_y;
    logic [11:0] left_x;
    logic [2:0]  latched;
    logic [2:0]  held;
    logic [11:0] cur_y;
    logic [11:0] cur_x;
  } cursor_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mct_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [mct_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mct_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mct_pkg::OutDataW-1:0] m_axis_tdata;

  // tracker model: registers and state
  logic        track_en = 1'b0;
  logic [7:0]  ratio_x = mct_pkg::RATIO_RESET;
  logic [7:0]  ratio_y = mct_pkg::RATIO_RESET;
  logic [11:0] max_x = mct_pkg::WIDTH_RESET;
  logic [11:0] max_y = mct_pkg::HEIGHT_RESET;
  logic [11:0] pos_x = '0, pos_y = '0;
  logic [7:0]  rem_x = '0, rem_y = '0;
  logic [15:0] last_x = '0, last_y = '0;
  logic [2:0]  held_bits = '0, latch_bits = '0;
  logic [11:0] cap_x [3] = '{default: '0};
  logic [11:0] cap_y [3] = '{default: '0};

  // stimulus side mickey counters
  logic [15:0] cnt_x = '0, cnt_y = '0;

  cursor_report_t reports_due[$];
  int unsigned errors = 0;
  logic src_gaps = 1'b0;
  logic sink_stalls = 1'b0;
  int stall_left = 0;
  cursor_report_t want, got;

  mouse_cursor_tracker_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // one axis: wrapped delta plus remainder, floor divided, then clipped
  task automatic move_axis(input logic [15:0] cnt, inout logic [15:0] last,
                           inout logic [7:0] rem, inout logic [11:0] pos,
                           input logic [7:0] ratio, input logic [11:0] lim);
    logic [15:0] diff;
    int delta, r, total, q, p, rem_i, pos_i, lim_i;
    diff = cnt - last;
    delta = int'($signed(diff));
    r = (ratio == 8'd0) ? 1 : int'(ratio);
    rem_i = int'(rem);
    pos_i = int'(pos);
    lim_i = int'(lim);
    total = rem_i + delta;
    if (total >= 0) begin
      q = total / r;
    end else begin
      q = -((-total + r - 1) / r);
    end
    rem = 8'(total - q * r);
    last = cnt;
    p = pos_i + q;
    if (p < 0) p = 0;
    if (p > lim_i) p = lim_i;
    pos = 12'(p);
  endtask

  // update the tracker state for one event and form its report
  task automatic advance_cursor(input mouse_event_t it, output cursor_report_t r);
    if (track_en) begin
      latch_bits = latch_bits & ~it.ack;
      for (int b = 0; b < 3; b++) begin
        if (it.bits[2*b+1]) begin
          held_bits[b] = 1'b1;
          if (!latch_bits[b]) begin
            latch_bits[b] = 1'b1;
            cap_x[b] = pos_x;
            cap_y[b] = pos_y;
          end
        end
        if (it.bits[2*b+2]) held_bits[b] = 1'b0;
      end
      move_axis(it.cnt_x, last_x, rem_x, pos_x, ratio_x, max_x);
      move_axis(it.cnt_y, last_y, rem_y, pos_y, ratio_y, max_y);
    end
    r = '0;
    r.cur_x = pos_x;
    r.cur_y = pos_y;
    r.held = held_bits;
    r.latched = latch_bits;
    r.left_x = cap_x[0];
    r.left_y = cap_y[0];
    r.right_x = cap_x[1];
    r.right_y = cap_y[1];
    r.mid_x = cap_x[2];
    r.mid_y = cap_y[2];
  endtask

  // receiver: ready with random stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // compare each report item with the oldest expected one
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (reports_due.size() == 0) begin
        $error("report item with none expected");
        errors++;
      end else begin
        want = reports_due.pop_front();
        got = m_axis_tdata;
        check_field("cursor_x", 32'(want.cur_x), 32'(got.cur_x));
        check_field("cursor_y", 32'(want.cur_y), 32'(got.cur_y));
        check_field("buttons_held", 32'(want.held), 32'(got.held));
        check_field("press_latched", 32'(want.latched), 32'(got.latched));
        check_field("left_press_x", 32'(want.left_x), 32'(got.left_x));
        check_field("left_press_y", 32'(want.left_y), 32'(got.left_y));
        check_field("right_press_x", 32'(want.right_x), 32'(got.right_x));
        check_field("right_press_y", 32'(want.right_y), 32'(got.right_y));
        check_field("middle_press_x", 32'(want.mid_x), 32'(got.mid_x));
        check_field("middle_press_y", 32'(want.mid_y), 32'(got.mid_y));
        check_field("zero_fill", 32'(want.fill), 32'(got.fill));
      end
    end
  end

  // send one event item, counters move by the given deltas
  task automatic send_event(logic [6:0] ev, int dx, int dy, logic [2:0] ack);
    mouse_event_t it;
    cursor_report_t r;
    cnt_x = cnt_x + dx[15:0];
    cnt_y = cnt_y + dy[15:0];
    it = '0;
    it.bits = ev;
    it.cnt_x = cnt_x;
    it.cnt_y = cnt_y;
    it.ack = ack;
    @(negedge clk_i);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_cursor(it, r);
    reports_due.push_back(r);
  endtask

  // stop sending and wait until every report item has come back
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write, only once the block is idle
  task automatic set_reg(logic [mct_pkg::CfgIdxW-1:0] idx, logic [mct_pkg::CfgW-1:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mct_pkg::CFG_ENABLE:        track_en = val[0];
      mct_pkg::CFG_X_RATIO:       ratio_x = val[7:0];
      mct_pkg::CFG_Y_RATIO:       ratio_y = val[7:0];
      mct_pkg::CFG_SCREEN_WIDTH:  max_x = val;
      mct_pkg::CFG_SCREEN_HEIGHT: max_y = val;
      default: ;
    endcase
  endtask

  // reset state: events must leave everything untouched
  task automatic test_disabled();
    send_event(7'h7f, 100, -50, 3'd7);
    send_event(7'h2a, 32767, 5, 3'd0);
  endtask

  // downs, ups, both at once, repeated presses and acks
  task automatic test_buttons();
    set_reg(mct_pkg::CFG_ENABLE, 12'd1);
    send_event(7'h02, 10, 5, 3'd0);
    send_event(7'h02, 3, 3, 3'd0);
    send_event(7'h18, 7, -2, 3'd0);
    send_event(7'h02, 1, 1, 3'd1);
    send_event(7'h21, -4, 9, 3'd0);
    send_event(7'h55, 0, 0, 3'd0);
    send_event(7'h7f, 2, 2, 3'd6);
    send_event(7'h00, 0, 0, 3'd7);
  endtask

  // counter extremes, ratio and screen extremes, stale remainder, clipping
  task automatic test_extremes();
    send_event(7'h00, 32767, 32768, 3'd0);
    set_reg(mct_pkg::CFG_SCREEN_WIDTH, 12'd4095);
    set_reg(mct_pkg::CFG_SCREEN_HEIGHT, 12'd4095);
    send_event(7'h08, 32767, 32767, 3'd0);
    set_reg(mct_pkg::CFG_X_RATIO, 12'd0);
    set_reg(mct_pkg::CFG_Y_RATIO, 12'd0);
    send_event(7'h00, -3, 2, 3'd0);
    set_reg(mct_pkg::CFG_X_RATIO, 12'd255);
    set_reg(mct_pkg::CFG_Y_RATIO, 12'd255);
    send_event(7'h00, -1, 254, 3'd0);
    // remainder left above the new ratio
    set_reg(mct_pkg::CFG_X_RATIO, 12'd7);
    set_reg(mct_pkg::CFG_Y_RATIO, 12'd1);
    send_event(7'h00, 0, 0, 3'd0);
    // screen shrunk below the cursor, no movement
    set_reg(mct_pkg::CFG_SCREEN_WIDTH, 12'd0);
    set_reg(mct_pkg::CFG_SCREEN_HEIGHT, 12'd0);
    send_event(7'h00, 0, 0, 3'd0);
    send_event(7'h20, -65535, 65535, 3'd0);
  endtask

  // mostly single button actions with modest motion, some noise
  task automatic random_event();
    logic [6:0] ev;
    logic [2:0] ack;
    int dx, dy, b;
    b = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ev = 7'h02 << (2 * b);
      4, 5, 6:    ev = 7'h04 << (2 * b);
      7:          ev = 7'h00;
      default:    ev = 7'($urandom_range(0, 127));
    endcase
    ack = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
    if ($urandom_range(0, 9) == 0) begin
      dx = $urandom;
      dy = $urandom;
    end else begin
      dx = int'($urandom_range(0, 1200)) - 600;
      dy = int'($urandom_range(0, 1200)) - 600;
    end
    send_event(ev, dx, dy, ack);
  endtask

  function automatic logic [mct_pkg::CfgW-1:0] pick_ratio();
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1, 2:    return 12'd1;
      3:       return 12'd255;
      default: return 12'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [mct_pkg::CfgW-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(1, 800));
    endcase
  endfunction

  // random phases, each under its own register setting
  task automatic test_random();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(mct_pkg::CFG_X_RATIO, pick_ratio());
      set_reg(mct_pkg::CFG_Y_RATIO, pick_ratio());
      set_reg(mct_pkg::CFG_SCREEN_WIDTH, pick_size());
      set_reg(mct_pkg::CFG_SCREEN_HEIGHT, pick_size());
      if (ph == 4) begin
        // a short disabled stretch in the middle
        set_reg(mct_pkg::CFG_ENABLE, 12'd0);
        repeat (10) random_event();
        set_reg(mct_pkg::CFG_ENABLE, 12'd1);
      end
      repeat (125) random_event();
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_back_to_back();
    set_reg(mct_pkg::CFG_X_RATIO, 12'd3);
    set_reg(mct_pkg::CFG_Y_RATIO, 12'd2);
    set_reg(mct_pkg::CFG_SCREEN_WIDTH, 12'd1023);
    set_reg(mct_pkg::CFG_SCREEN_HEIGHT, 12'd767);
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (150) random_event();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_disabled();
    test_buttons();
    test_extremes();
    test_random();
    test_back_to_back();
    settle();
    repeat (40) @(negedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
